FILE: hdl/apct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apct_pkg;

    localparam int SLOTS_DEF = 8;

    localparam logic [63:0] MATRIX_RESET = 64'd15453661431808;

    // input kinds
    localparam logic [2:0] KIND_ADD     = 3'd0;
    localparam logic [2:0] KIND_MARK    = 3'd1;
    localparam logic [2:0] KIND_SWEEP   = 3'd2;
    localparam logic [2:0] KIND_CLR_MAP = 3'd3;
    localparam logic [2:0] KIND_CLR_ALL = 3'd4;

    // collider types
    localparam logic [2:0] CT_NONE     = 3'd0;
    localparam logic [2:0] CT_FLOOR    = 3'd1;
    localparam logic [2:0] CT_PLATFORM = 3'd2;
    localparam logic [2:0] CT_PLAYER   = 3'd3;
    localparam logic [2:0] CT_DEATH    = 3'd4;
    localparam logic [2:0] CT_WIN      = 3'd5;
    localparam logic [2:0] CT_ATTACK   = 3'd6;
    localparam logic [2:0] CT_ENEMY    = 3'd7;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [2:0]         ctype;
        logic               notify;
    } box_t;

    // map geometry that a map clear frees
    function automatic logic is_map_type(input logic [2:0] t);
        logic r;
        case (t) inside
            CT_FLOOR, CT_PLATFORM, CT_DEATH, CT_WIN: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/apct_box_store.sv
`timescale 1ns / 1ps
`default_nettype none

module apct_box_store
    import apct_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire box_t             wdata,
    input  wire logic [IDX_W-1:0] raddr_a,
    input  wire logic [IDX_W-1:0] raddr_b,
    output box_t                  rdata_a,
    output box_t                  rdata_b
);

    box_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads, two ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: hdl/apct_overlap.sv
`timescale 1ns / 1ps
`default_nettype none

module apct_overlap
    import apct_pkg::*;
(
    input  wire box_t a,
    input  wire box_t b,
    output logic      hit
);

    logic signed [16:0] a_l, a_r, a_t, a_b;
    logic signed [16:0] b_l, b_r, b_t, b_b;

    // widen by one bit so edge sums never wrap
    always_comb
    begin
        a_l = {a.x[15], a.x};
        a_t = {a.y[15], a.y};
        b_l = {b.x[15], b.x};
        b_t = {b.y[15], b.y};
        a_r = a_l + $signed({2'b00, a.w});
        a_b = a_t + $signed({2'b00, a.h});
        b_r = b_l + $signed({2'b00, b.w});
        b_b = b_t + $signed({2'b00, b.h});
        hit = (a_l < b_r) && (a_r > b_l) && (a_t < b_b) && (a_b > b_t);
    end

endmodule

`default_nettype wire

FILE: hdl/aabb_pair_collision_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Add, mark, map clear, clear all and unused kinds give their one item the cycle
// after acceptance; with results taken, a new item is accepted every cycle.
// A sweep walks SLOTS*(SLOTS-1)/2 pairs through one overlap unit: each pair once, each pair
// that notifies k about i once more, then a closing state. No new item is taken until the
// sweep has given its last item; output stalls hold the walk.
// Reset (rst_n low, asynchronous) empties the table, clears marks, loads the default matrix.
module aabb_pair_collision_table
    import apct_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration: type permission matrix
    input  wire logic               cfg_we,
    input  wire logic [63:0]        cfg_data,
    // input items
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         kind,
    input  wire logic signed [15:0] box_x,
    input  wire logic signed [15:0] box_y,
    input  wire logic [14:0]        box_w,
    input  wire logic [14:0]        box_h,
    input  wire logic [2:0]         box_type,
    input  wire logic               has_notify,
    input  wire logic [2:0]         slot_index,
    // result items
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    is_hit,
    output logic [2:0]              self_slot,
    output logic [2:0]              other_slot,
    output logic                    table_full,
    output logic                    last
);

    localparam int IDX_W = $clog2(SLOTS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // control state
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             ph_reg, ph_next;        // 0: notify i about k, 1: k about i
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] rm_reg, rm_next;        // marked for removal at next sweep
    logic [SLOTS-1:0] map_reg, map_next;      // slot holds a map-geometry type
    logic [63:0]      matrix_reg;

    // one notification held back until we know whether it is the last
    logic             pv_reg, pv_next;
    logic [IDX_W-1:0] ps_reg, ps_next;
    logic [IDX_W-1:0] po_reg, po_next;

    // output register
    logic             out_valid_reg;
    logic             hit_reg, full_reg, last_reg;
    logic [2:0]       self_reg, other_reg;

    logic             out_free, out_load;
    logic             o_hit, o_full, o_last;
    logic [2:0]       o_self, o_other;

    logic             in_accept;
    logic             add_we;
    logic [IDX_W-1:0] free_idx;
    logic             tbl_full;
    logic [IDX_W-1:0] mark_idx;
    logic             mark_ok;

    box_t             new_box, box_a, box_b;
    logic             ovl, h_base, h1, h2;
    logic             cur_hit, stall, last_pair;
    logic [IDX_W-1:0] cur_self, cur_other;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_accept = in_valid && in_ready;

    assign out_valid  = out_valid_reg;
    assign is_hit     = hit_reg;
    assign self_slot  = self_reg;
    assign other_slot = other_reg;
    assign table_full = full_reg;
    assign last       = last_reg;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!used_reg[s])
            begin
                free_idx = IDX_W'(s);
            end
        end
        tbl_full = &used_reg;
    end

    assign mark_idx = slot_index[IDX_W-1:0];
    assign mark_ok  = ({1'b0, slot_index} < 4'(SLOTS)) && used_reg[mark_idx];

    always_comb
    begin
        new_box.x      = box_x;
        new_box.y      = box_y;
        new_box.w      = box_w;
        new_box.h      = box_h;
        new_box.ctype  = box_type;
        new_box.notify = has_notify;
    end

    // box store: read addresses follow the next pair so the data lines up with i_reg/k_reg
    apct_box_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk     (clk),
        .we      (add_we),
        .waddr   (free_idx),
        .wdata   (new_box),
        .raddr_a (i_next),
        .raddr_b (k_next),
        .rdata_a (box_a),
        .rdata_b (box_b)
    );

    // the one shared overlap unit
    apct_overlap u_overlap (
        .a   (box_a),
        .b   (box_b),
        .hit (ovl)
    );

    // gate each direction by the permission matrix and the notify flag of self
    assign h_base    = used_reg[i_reg] && used_reg[k_reg] && ovl;
    assign h1        = h_base && matrix_reg[{box_a.ctype, box_b.ctype}] && box_a.notify;
    assign h2        = h_base && matrix_reg[{box_b.ctype, box_a.ctype}] && box_b.notify;
    assign cur_hit   = ph_reg ? h2 : h1;
    assign cur_self  = ph_reg ? k_reg : i_reg;
    assign cur_other = ph_reg ? i_reg : k_reg;
    // a new hit pushes the held one out, which needs a free output register
    assign stall     = cur_hit && pv_reg && !out_free;
    assign last_pair = (i_reg == IDX_W'(SLOTS - 2)) && (k_reg == IDX_W'(SLOTS - 1));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        used_next  = used_reg;
        rm_next    = rm_reg;
        map_next   = map_reg;
        pv_next    = pv_reg;
        ps_next    = ps_reg;
        po_next    = po_reg;
        add_we     = 1'b0;
        out_load   = 1'b0;
        o_hit      = 1'b0;
        o_self     = '0;
        o_other    = '0;
        o_full     = 1'b0;
        o_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    out_load = 1'b1;
                    unique case (kind)
                        KIND_ADD:
                        begin
                            if (tbl_full)
                            begin
                                o_full = 1'b1;
                            end
                            else
                            begin
                                add_we             = 1'b1;
                                used_next[free_idx] = 1'b1;
                                rm_next[free_idx]   = 1'b0;
                                map_next[free_idx]  = is_map_type(box_type);
                                o_self             = 3'(free_idx);
                            end
                        end
                        KIND_MARK:
                        begin
                            if (mark_ok)
                            begin
                                rm_next[mark_idx] = 1'b1;
                            end
                        end
                        KIND_SWEEP:
                        begin
                            // drop marked slots, then walk the pairs
                            out_load   = 1'b0;
                            used_next  = used_reg & ~rm_reg;
                            rm_next    = '0;
                            ph_next    = 1'b0;
                            state_next = S_SCAN;
                        end
                        KIND_CLR_MAP:
                        begin
                            used_next = used_reg & ~map_reg;
                            rm_next   = rm_reg & ~map_reg;
                        end
                        KIND_CLR_ALL:
                        begin
                            used_next = '0;
                            rm_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    if (cur_hit)
                    begin
                        if (pv_reg)
                        begin
                            out_load = 1'b1;
                            o_hit    = 1'b1;
                            o_self   = 3'(ps_reg);
                            o_other  = 3'(po_reg);
                            o_last   = 1'b0;
                        end
                        pv_next = 1'b1;
                        ps_next = cur_self;
                        po_next = cur_other;
                    end
                    if (!ph_reg && h2)
                    begin
                        // hold the pair for the reverse direction
                        ph_next = 1'b1;
                    end
                    else
                    begin
                        ph_next = 1'b0;
                        if (last_pair)
                        begin
                            i_next     = '0;
                            k_next     = IDX_W'(1);
                            state_next = S_FINISH;
                        end
                        else if (k_reg == IDX_W'(SLOTS - 1))
                        begin
                            i_next = i_reg + IDX_W'(1);
                            k_next = i_reg + IDX_W'(2);
                        end
                        else
                        begin
                            k_next = k_reg + IDX_W'(1);
                        end
                    end
                end
            end

            S_FINISH:
            begin
                // release the held notification as the last item, or an empty last item
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (pv_reg)
                    begin
                        o_hit   = 1'b1;
                        o_self  = 3'(ps_reg);
                        o_other = 3'(po_reg);
                    end
                    pv_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            k_reg         <= IDX_W'(1);
            ph_reg        <= 1'b0;
            used_reg      <= '0;
            rm_reg        <= '0;
            map_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            matrix_reg    <= MATRIX_RESET;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
            used_reg  <= used_next;
            rm_reg    <= rm_next;
            map_reg   <= map_next;
            pv_reg    <= pv_next;
            if (cfg_we)
            begin
                matrix_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ps_reg <= ps_next;
        po_reg <= po_next;
        if (out_load)
        begin
            hit_reg   <= o_hit;
            self_reg  <= o_self;
            other_reg <= o_other;
            full_reg  <= o_full;
            last_reg  <= o_last;
        end
    end

`ifndef SYNTHESIS
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg > i_reg))
        else $error("pair walk left i < k order");

    a_held_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == S_SCAN || state_reg == S_FINISH))
        else $error("held notification outside a sweep");

    a_marks_on_used: assert property (@(posedge clk) disable iff (!rst_n)
        (rm_reg & ~used_reg) == '0)
        else $error("removal mark on a free slot");

    a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> !full_reg)
        else $error("notification item flagged full");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && kind != KIND_SWEEP) |=> (out_valid_reg && last_reg && state_reg == S_IDLE))
        else $error("non-sweep item gave no last result");
`endif

endmodule

`default_nettype wire

FILE: tb/aabb_pair_collision_table_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the box collision table. A predictor keeps its own copy of the
// slots, the pending marks and the type matrix. It works out the result items for every
// accepted input item and queues them. A checker compares each accepted result item,
// field by field, with the oldest queued one. Both sides idle at random, so that gaps hit
// the add, mark and sweep paths alike.
module aabb_pair_collision_table_tb;
    import apct_pkg::*;

    // quiet cycles (no item moving on either side) before the run is called hung
    localparam int          WATCHDOG_LIMIT = 3000;
    // cycles to keep watching after the last expected item, to catch stray output
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          RANDOM_ITEMS   = 452;

    // kinds the block has no use for; they must still answer with one closing item
    localparam logic [2:0]  KIND_SPARE5 = 3'd5;
    localparam logic [2:0]  KIND_SPARE6 = 3'd6;
    localparam logic [2:0]  KIND_SPARE7 = 3'd7;

    localparam logic [63:0] MATRIX_NONE = '0;
    localparam logic [63:0] MATRIX_ALL  = '1;

    // one result item as the block should present it
    typedef struct packed {
        logic       hit;
        logic [2:0] self_s;
        logic [2:0] other_s;
        logic       full;
        logic       lst;
    } note_t;

    // one input item
    typedef struct packed {
        logic [2:0] kind;
        box_t       box;
        logic [2:0] slot;
    } req_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [63:0]        cfg_data      = '0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [2:0]         kind          = '0;
    logic signed [15:0] box_x         = '0;
    logic signed [15:0] box_y         = '0;
    logic [14:0]        box_w         = '0;
    logic [14:0]        box_h         = '0;
    logic [2:0]         box_type      = '0;
    logic               has_notify    = 1'b0;
    logic [2:0]         slot_index    = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic               is_hit;
    logic [2:0]         self_slot;
    logic [2:0]         other_slot;
    logic               table_full;
    logic               last;

    // predictor copy of the block state
    logic [63:0] matrix_copy = MATRIX_RESET;
    bit          slot_taken [SLOTS_DEF];
    bit          marked     [SLOTS_DEF];
    box_t        boxes      [SLOTS_DEF];

    // result items owed by the block, oldest first
    note_t notes_due [$];

    int errors       = 0;
    int quiet_cycles = 0;
    int ready_hold   = 0;
    bit idle_on      = 1'b0;

    aabb_pair_collision_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .box_x         (box_x),
        .box_y         (box_y),
        .box_w         (box_w),
        .box_h         (box_h),
        .box_type      (box_type),
        .has_notify    (has_notify),
        .slot_index    (slot_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_hit        (is_hit),
        .self_slot     (self_slot),
        .other_slot    (other_slot),
        .table_full    (table_full),
        .last          (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then a long one.
    // Return zero throughout a stretch where idling is off.
    function automatic int pause_len();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic box_t box_of(input int x, input int y, input int w, input int h,
                                    input logic [2:0] ct, input logic nf);
        box_t b;
        b.x      = 16'(x);
        b.y      = 16'(y);
        b.w      = 15'(w);
        b.h      = 15'(h);
        b.ctype  = ct;
        b.notify = nf;
        return b;
    endfunction

    // Clustered boxes overlap often; spread boxes cover every bit of every field.
    function automatic box_t random_box(input bit spread);
        box_t b;
        b.ctype  = 3'($urandom_range(0, 7));
        b.notify = 1'($urandom_range(0, 1));
        if (spread)
        begin
            b.x = 16'($urandom);
            b.y = 16'($urandom);
            b.w = 15'($urandom);
            b.h = 15'($urandom);
        end
        else
        begin
            b.x = 16'(int'($urandom_range(0, 80)) - 40);
            b.y = 16'(int'($urandom_range(0, 80)) - 40);
            b.w = 15'($urandom_range(0, 30));
            b.h = 15'($urandom_range(0, 30));
        end
        return b;
    endfunction

    // Strict overlap on 32-bit sums, so edges near the 16-bit limits do not wrap.
    function automatic bit boxes_overlap(input box_t a, input box_t b);
        int ax, ay, aw, ah;
        int bx, by, bw, bh;
        ax = int'($signed(a.x));
        ay = int'($signed(a.y));
        aw = int'(a.w);
        ah = int'(a.h);
        bx = int'($signed(b.x));
        by = int'($signed(b.y));
        bw = int'(b.w);
        bh = int'(b.h);
        return ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
    endfunction

    function automatic bit may_notify(input int s, input int o);
        return matrix_copy[{boxes[s].ctype, boxes[o].ctype}] && boxes[s].notify;
    endfunction

    function automatic note_t hit_note(input int s, input int o);
        note_t n;
        n         = '0;
        n.hit     = 1'b1;
        n.self_s  = 3'(s);
        n.other_s = 3'(o);
        return n;
    endfunction

    // Advance the predicted table by one accepted item and queue what it must produce.
    task automatic apply_item(input req_t r);
        note_t done_note;
        note_t hits [$];
        bit    placed;
        int    i, k;
        done_note     = '0;
        done_note.lst = 1'b1;
        placed        = 1'b0;
        case (r.kind)
            KIND_ADD:
            begin
                for (i = 0; i < SLOTS_DEF; i++)
                begin
                    if (!placed && !slot_taken[i])
                    begin
                        placed           = 1'b1;
                        slot_taken[i]    = 1'b1;
                        marked[i]        = 1'b0;
                        boxes[i]         = r.box;
                        done_note.self_s = 3'(i);
                    end
                end
                if (!placed)
                    done_note.full = 1'b1;
            end
            KIND_MARK:
            begin
                if (slot_taken[r.slot])
                    marked[r.slot] = 1'b1;
            end
            KIND_SWEEP:
            begin
                // drop marked slots first, then walk the pairs in slot order
                for (i = 0; i < SLOTS_DEF; i++)
                begin
                    if (slot_taken[i] && marked[i])
                    begin
                        slot_taken[i] = 1'b0;
                        marked[i]     = 1'b0;
                    end
                end
                for (i = 0; i < SLOTS_DEF; i++)
                begin
                    for (k = i + 1; k < SLOTS_DEF; k++)
                    begin
                        if (slot_taken[i] && slot_taken[k] &&
                            boxes_overlap(boxes[i], boxes[k]))
                        begin
                            if (may_notify(i, k))
                                hits.push_back(hit_note(i, k));
                            if (may_notify(k, i))
                                hits.push_back(hit_note(k, i));
                        end
                    end
                end
            end
            KIND_CLR_MAP:
            begin
                for (i = 0; i < SLOTS_DEF; i++)
                begin
                    if (slot_taken[i] &&
                        boxes[i].ctype inside {CT_FLOOR, CT_PLATFORM, CT_DEATH, CT_WIN})
                    begin
                        slot_taken[i] = 1'b0;
                        marked[i]     = 1'b0;
                    end
                end
            end
            KIND_CLR_ALL:
            begin
                for (i = 0; i < SLOTS_DEF; i++)
                begin
                    slot_taken[i] = 1'b0;
                    marked[i]     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (hits.size() > 0)
        begin
            hits[hits.size() - 1].lst = 1'b1;
            foreach (hits[j])
                notes_due.push_back(hits[j]);
        end
        else
        begin
            notes_due.push_back(done_note);
        end
    endtask

    // Send one item: idle for a random gap, present it, hold it until taken, then
    // update the prediction. Always entered and left on a rising-edge step.
    task automatic offer_item(input req_t r);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= r.kind;
        box_x         <= r.box.x;
        box_y         <= r.box.y;
        box_w         <= r.box.w;
        box_h         <= r.box.h;
        box_type      <= r.box.ctype;
        has_notify    <= r.box.notify;
        slot_index    <= r.slot;
        do
            @(posedge clk);
        while (!in_ready);
        apply_item(r);
    endtask

    task automatic offer_add(input box_t b);
        req_t r;
        r.kind = KIND_ADD;
        r.box  = b;
        r.slot = 3'($urandom_range(0, 7));
        offer_item(r);
    endtask

    // Non-add kinds carry random box fields; the block must ignore them.
    task automatic offer_cmd(input logic [2:0] k, input logic [2:0] s);
        req_t r;
        r.kind = k;
        r.box  = random_box(1'b1);
        r.slot = s;
        offer_item(r);
    endtask

    // Stop sending and wait until every owed item has come back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (notes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the matrix only while the block is idle.
    task automatic load_type_matrix(input logic [63:0] value);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        matrix_copy = value;
    endtask

    function automatic req_t random_req();
        req_t r;
        int   roll;
        roll   = $urandom_range(0, 99);
        r.box  = random_box($urandom_range(0, 5) == 0);
        r.slot = 3'($urandom_range(0, 7));
        if (roll < 42)
            r.kind = KIND_ADD;
        else if (roll < 58)
        begin
            r.kind = KIND_MARK;
            // steer most marks onto occupied slots; the rest stay as noise
            if ($urandom_range(0, 3) != 0)
                repeat (8)
                    if (!slot_taken[r.slot])
                        r.slot = 3'($urandom_range(0, 7));
        end
        else if (roll < 84)
            r.kind = KIND_SWEEP;
        else if (roll < 90)
            r.kind = KIND_CLR_MAP;
        else if (roll < 95)
            r.kind = KIND_CLR_ALL;
        else
        begin
            case ($urandom_range(0, 2))
                0:       r.kind = KIND_SPARE5;
                1:       r.kind = KIND_SPARE6;
                default: r.kind = KIND_SPARE7;
            endcase
        end
        return r;
    endfunction

    // Fill all slots with boxes at the field extremes and every type, overflow the
    // table once, then sweep with every permission open.
    task automatic test_fill_and_overflow();
        idle_on = 1'b0;
        hold_until_drained();
        load_type_matrix(MATRIX_ALL);
        offer_add(box_of(-32768, -32768, 32767, 32767, CT_NONE, 1'b1));
        offer_add(box_of(32767, 32767, 32767, 32767, CT_FLOOR, 1'b0));
        offer_add(box_of(0, 0, 0, 0, CT_PLATFORM, 1'b1));
        offer_add(box_of(-5, -5, 10, 10, CT_PLAYER, 1'b1));
        offer_add(box_of(-1, -1, 2, 2, CT_DEATH, 1'b0));
        offer_add(box_of(3, 3, 1, 1, CT_WIN, 1'b1));
        offer_add(box_of(-100, 0, 95, 1, CT_ATTACK, 1'b1));
        offer_add(box_of(4, -9, 7, 20, CT_ENEMY, 1'b1));
        offer_add(box_of(1, 1, 1, 1, CT_PLAYER, 1'b1));
        offer_cmd(KIND_SWEEP, '0);
        offer_cmd(KIND_CLR_ALL, '0);
    endtask

    // Boxes that only touch, or have zero width on a shared edge, must not count.
    task automatic test_touching_edges();
        idle_on = 1'b1;
        offer_add(box_of(0, 0, 10, 10, CT_PLAYER, 1'b1));
        offer_add(box_of(10, 0, 5, 10, CT_ENEMY, 1'b1));
        offer_add(box_of(10, 0, 0, 10, CT_ATTACK, 1'b1));
        offer_add(box_of(9, 9, 1, 1, CT_ENEMY, 1'b1));
        offer_cmd(KIND_SWEEP, '0);
        offer_cmd(KIND_CLR_ALL, '0);
    endtask

    // Mark a used and a free slot, sweep away the mark, clear map geometry, and send
    // the kinds the block ignores.
    task automatic test_marks_and_clears();
        idle_on = 1'b1;
        hold_until_drained();
        load_type_matrix(MATRIX_RESET);
        offer_add(box_of(0, 0, 20, 20, CT_FLOOR, 1'b1));
        offer_add(box_of(5, 5, 4, 4, CT_PLAYER, 1'b1));
        offer_add(box_of(10, 10, 30, 30, CT_WIN, 1'b1));
        offer_add(box_of(2, 2, 3, 3, CT_ENEMY, 1'b1));
        offer_cmd(KIND_MARK, 3'd1);
        offer_cmd(KIND_MARK, 3'd6);
        offer_cmd(KIND_SWEEP, '0);
        offer_cmd(KIND_CLR_MAP, '0);
        offer_cmd(KIND_SPARE5, '0);
        offer_cmd(KIND_SPARE7, '0);
        offer_cmd(KIND_SWEEP, '0);
    endtask

    // Random scenes in phases. Each phase drains the block, loads a new matrix (none,
    // all, default or random) and picks whether both sides idle.
    task automatic test_random_scenes();
        req_t r;
        int   phase;
        int   sent;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            hold_until_drained();
            case (phase % 6)
                0:       load_type_matrix(MATRIX_NONE);
                1:       load_type_matrix(MATRIX_ALL);
                2:       load_type_matrix(MATRIX_RESET);
                default: load_type_matrix({$urandom, $urandom});
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 40 && sent < RANDOM_ITEMS; n++)
            begin
                r = random_req();
                offer_item(r);
                sent++;
            end
            phase++;
        end
    endtask

    task automatic compare_field(input string name, input logic [2:0] want_v,
                                 input logic [2:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    // Check every accepted result item against the oldest one owed.
    always @(posedge clk)
    begin
        note_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (notes_due.size() == 0)
            begin
                errors++;
                $display("%0t: result item with none expected: hit %0d self %0d other %0d %s",
                         $time, is_hit, self_slot, other_slot,
                         $sformatf("full %0d last %0d", table_full, last));
            end
            else
            begin
                want = notes_due.pop_front();
                compare_field("is_hit", {2'b00, want.hit}, {2'b00, is_hit});
                compare_field("self_slot", want.self_s, self_slot);
                compare_field("other_slot", want.other_s, other_slot);
                compare_field("table_full", {2'b00, want.full}, {2'b00, table_full});
                compare_field("last", {2'b00, want.lst}, {2'b00, last});
            end
        end
    end

    // Result side: hold ready low for a random stretch now and then.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                ready_hold <= pause_len();
        end
    end

    // Abort when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL aabb_pair_collision_table");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_and_overflow();
        test_touching_edges();
        test_marks_and_clears();
        test_random_scenes();
        in_valid <= 1'b0;
        while (notes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && notes_due.size() == 0)
            $display("PASS aabb_pair_collision_table");
        else
            $display("FAIL aabb_pair_collision_table");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/apct_pkg.sv
hdl/apct_box_store.sv
hdl/apct_overlap.sv
hdl/aabb_pair_collision_table.sv
tb/aabb_pair_collision_table_tb.sv
